// ===== hdl/demand_paging_translator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the demand paging translator
// Concurrent checks clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DEMAND_PAGING_TRANSLATOR_TOP_ASSERT_SVH
`define DEMAND_PAGING_TRANSLATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define DPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dpt_pkg.sv =====
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types, widths, register codes and helpers of the paging translator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpt_pkg;

    // Default sizes
    localparam int VIRT_PAGES_DEF     = 64;
    localparam int PHYS_FRAMES_DEF    = 16;
    localparam int MAX_PAGE_SHIFT_DEF = 12;

    // Fixed field widths
    localparam int ADDR_W       = 18;
    localparam int PHYS_ADDR_W  = 16;
    localparam int EVICT_PAGE_W = 6;
    localparam int STAMP_W      = 32;

    // Configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int PAGE_SHIFT_W = 4;
    localparam int VPAGES_CFG_W = 7;
    localparam int FRAMES_CFG_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VPAGES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 2'd3;

    // Register reset values
    localparam logic [PAGE_SHIFT_W-1:0] PAGE_SHIFT_RST = 4'd12;
    localparam logic [VPAGES_CFG_W-1:0] VPAGES_RST     = 7'd64;
    localparam logic [FRAMES_CFG_W-1:0] FRAMES_RST     = 5'd16;
    localparam logic                    POLICY_RST     = 1'b0;

    // Flags carried from cell to cell during a search walk
    typedef struct packed {
        logic valid;
        logic hit;
        logic free_found;
        logic have;
    } link_flags_t;

    // Broadcast update to the frame cells
    typedef struct packed {
        logic load;   // install a page, set both stamps
        logic touch;  // refresh the use stamp
    } cell_cmd_t;

    // Index width for n entries, at least one bit
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Width that holds the count n itself
    function automatic int cnt_w(input int n);
        return $clog2(n + 1);
    endfunction

endpackage

// ===== hdl/dpt_frame_cell.sv =====
// ----------------------------------------------------------------------------
// dpt_frame_cell
// One physical frame: owner page, busy bit, load and use stamps. Folds its
// state into the search record walking down the row and hands it on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpt_frame_cell #(
    parameter int VIRT_PAGES  = dpt_pkg::VIRT_PAGES_DEF,
    parameter int PHYS_FRAMES = dpt_pkg::PHYS_FRAMES_DEF,
    parameter int CELL_IDX    = 0
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // broadcast lookup context
    input  logic [dpt_pkg::idx_w(VIRT_PAGES)-1:0]       page_i,
    input  logic [dpt_pkg::cnt_w(PHYS_FRAMES)-1:0]      nframes_i,
    input  logic                                        policy_i,
    // broadcast update
    input  dpt_pkg::cell_cmd_t                          cmd_i,
    input  logic [dpt_pkg::idx_w(PHYS_FRAMES)-1:0]      cmd_frame_i,
    input  logic [dpt_pkg::idx_w(VIRT_PAGES)-1:0]       cmd_page_i,
    input  logic [dpt_pkg::STAMP_W-1:0]                 cmd_stamp_i,
    // search record from the previous cell
    input  dpt_pkg::link_flags_t                        fl_i,
    input  logic [dpt_pkg::idx_w(PHYS_FRAMES)-1:0]      hit_frame_i,
    input  logic [dpt_pkg::idx_w(PHYS_FRAMES)-1:0]      free_frame_i,
    input  logic [dpt_pkg::idx_w(PHYS_FRAMES)-1:0]      best_frame_i,
    input  logic [dpt_pkg::idx_w(VIRT_PAGES)-1:0]       best_owner_i,
    input  logic [dpt_pkg::STAMP_W-1:0]                 best_stamp_i,
    // search record to the next cell
    output dpt_pkg::link_flags_t                        fl_o,
    output logic [dpt_pkg::idx_w(PHYS_FRAMES)-1:0]      hit_frame_o,
    output logic [dpt_pkg::idx_w(PHYS_FRAMES)-1:0]      free_frame_o,
    output logic [dpt_pkg::idx_w(PHYS_FRAMES)-1:0]      best_frame_o,
    output logic [dpt_pkg::idx_w(VIRT_PAGES)-1:0]       best_owner_o,
    output logic [dpt_pkg::STAMP_W-1:0]                 best_stamp_o
);
    import dpt_pkg::*;

    localparam int PW  = idx_w(VIRT_PAGES);
    localparam int FW  = idx_w(PHYS_FRAMES);
    localparam int NFW = cnt_w(PHYS_FRAMES);
    localparam logic [FW-1:0] MY_IDX = FW'(CELL_IDX);

    // Frame state
    logic               busy_reg;
    logic [PW-1:0]      owner_reg;
    logic [STAMP_W-1:0] load_stamp_reg;
    logic [STAMP_W-1:0] use_stamp_reg;

    // Search record register
    link_flags_t        fl_reg,         fl_next;
    logic [FW-1:0]      hit_frame_reg,  hit_frame_next;
    logic [FW-1:0]      free_frame_reg, free_frame_next;
    logic [FW-1:0]      best_frame_reg, best_frame_next;
    logic [PW-1:0]      best_owner_reg, best_owner_next;
    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;

    logic               in_range;
    logic               owns_page;
    logic               sel_cmd;
    logic [STAMP_W-1:0] my_stamp;

    assign in_range  = NFW'(CELL_IDX) < nframes_i;
    assign owns_page = busy_reg && (owner_reg == page_i);
    assign my_stamp  = policy_i ? use_stamp_reg : load_stamp_reg;
    assign sel_cmd   = (cmd_frame_i == MY_IDX);

    // Fold this frame into the search record
    always_comb begin
        fl_next         = fl_i;
        hit_frame_next  = hit_frame_i;
        free_frame_next = free_frame_i;
        best_frame_next = best_frame_i;
        best_owner_next = best_owner_i;
        best_stamp_next = best_stamp_i;
        if (owns_page && !fl_i.hit) begin
            fl_next.hit    = 1'b1;
            hit_frame_next = MY_IDX;
        end
        if (in_range && !busy_reg && !fl_i.free_found) begin
            fl_next.free_found = 1'b1;
            free_frame_next    = MY_IDX;
        end
        // strict less-than keeps the lowest frame on ties
        if (in_range && busy_reg && (!fl_i.have || (my_stamp < best_stamp_i))) begin
            fl_next.have    = 1'b1;
            best_frame_next = MY_IDX;
            best_owner_next = owner_reg;
            best_stamp_next = my_stamp;
        end
    end

    // Record register: valid travels every cycle, payload holds once the
    // walk has passed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fl_reg.valid <= 1'b0;
        end else begin
            fl_reg.valid <= fl_i.valid;
        end
        if (fl_i.valid) begin
            fl_reg.hit        <= fl_next.hit;
            fl_reg.free_found <= fl_next.free_found;
            fl_reg.have       <= fl_next.have;
            hit_frame_reg     <= hit_frame_next;
            free_frame_reg    <= free_frame_next;
            best_frame_reg    <= best_frame_next;
            best_owner_reg    <= best_owner_next;
            best_stamp_reg    <= best_stamp_next;
        end
    end

    // Frame occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd_i.load && sel_cmd) begin
            busy_reg <= 1'b1;
        end
    end

    // Owner and stamps
    always_ff @(posedge aclk) begin
        if (cmd_i.load && sel_cmd) begin
            owner_reg      <= cmd_page_i;
            load_stamp_reg <= cmd_stamp_i;
            use_stamp_reg  <= cmd_stamp_i;
        end else if (cmd_i.touch && sel_cmd) begin
            use_stamp_reg  <= cmd_stamp_i;
        end
    end

    assign fl_o         = fl_reg;
    assign hit_frame_o  = hit_frame_reg;
    assign free_frame_o = free_frame_reg;
    assign best_frame_o = best_frame_reg;
    assign best_owner_o = best_owner_reg;
    assign best_stamp_o = best_stamp_reg;

endmodule

// ===== hdl/demand_paging_translator_top.sv =====
// ----------------------------------------------------------------------------
// demand_paging_translator_top
// Translates byte virtual addresses through a demand-paged page table with
// FIFO or LRU replacement. Residency lives in a row of frame cells, one per
// physical frame; each lookup walks a search record down the row, one cell
// per clock. One address is handled at a time: an in-range address passes
// a check state, the walk through every frame cell, a commit state and an
// idle state before the next input transfer; an out-of-range address skips
// the walk. The commit stalls while a previous result is still waiting on
// m_ready. There is no clearing pass after reset. A configuration write is
// registered. Configuration writes must only be issued while the block is
// idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "demand_paging_translator_top_assert.svh"

module demand_paging_translator_top #(
    parameter int VIRT_PAGES     = dpt_pkg::VIRT_PAGES_DEF,
    parameter int PHYS_FRAMES    = dpt_pkg::PHYS_FRAMES_DEF,
    parameter int MAX_PAGE_SHIFT = dpt_pkg::MAX_PAGE_SHIFT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [dpt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dpt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // address channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dpt_pkg::ADDR_W-1:0]          s_virt_addr,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dpt_pkg::PHYS_ADDR_W-1:0]     m_phys_addr,
    output logic                                m_out_of_range,
    output logic                                m_was_hit,
    output logic                                m_evicted_valid,
    output logic [dpt_pkg::EVICT_PAGE_W-1:0]    m_evicted_page
);
    import dpt_pkg::*;

    localparam int PW   = idx_w(VIRT_PAGES);
    localparam int FW   = idx_w(PHYS_FRAMES);
    localparam int NFW  = cnt_w(PHYS_FRAMES);
    localparam int VPW  = cnt_w(VIRT_PAGES);
    localparam int SHW  = (MAX_PAGE_SHIFT > 0) ? $clog2(MAX_PAGE_SHIFT + 1) : 1;
    localparam int LW   = VPW + MAX_PAGE_SHIFT;
    localparam int CMPW = (LW > ADDR_W) ? LW : ADDR_W;
    localparam int MW   = PHYS_ADDR_W + 1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Configuration registers
    logic [PAGE_SHIFT_W-1:0] page_shift_reg;
    logic [VPAGES_CFG_W-1:0] vpages_cfg_reg;
    logic [FRAMES_CFG_W-1:0] frames_cfg_reg;
    logic                    policy_reg;

    // Sequencer and item registers
    logic [1:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       addr_reg,  addr_next;
    logic [STAMP_W-1:0]      tick_reg,  tick_next;
    logic                    oor_reg,   oor_next;

    // Output register
    logic                    m_valid_reg,     m_valid_next;
    logic [PHYS_ADDR_W-1:0]  m_phys_reg,      m_phys_next;
    logic                    m_oor_reg,       m_oor_next;
    logic                    m_hit_reg,       m_hit_next;
    logic                    m_ev_valid_reg,  m_ev_valid_next;
    logic [EVICT_PAGE_W-1:0] m_ev_page_reg,   m_ev_page_next;

    // Effective configuration
    logic [SHW-1:0]          shift_eff;
    logic [VPW-1:0]          vpages_eff;
    logic [NFW-1:0]          nframes_eff;

    // Address decode
    logic [CMPW-1:0]         limit_cmp;
    logic                    addr_oor;
    logic [PW-1:0]           page_cur;
    logic [MW-1:0]           off_mask;
    logic [PHYS_ADDR_W-1:0]  phys_calc;

    // Search chain links, link 0 feeds the first cell
    link_flags_t             lk_fl         [PHYS_FRAMES+1];
    logic [FW-1:0]           lk_hit_frame  [PHYS_FRAMES+1];
    logic [FW-1:0]           lk_free_frame [PHYS_FRAMES+1];
    logic [FW-1:0]           lk_best_frame [PHYS_FRAMES+1];
    logic [PW-1:0]           lk_best_owner [PHYS_FRAMES+1];
    logic [STAMP_W-1:0]      lk_best_stamp [PHYS_FRAMES+1];

    logic                    launch;
    logic                    out_free;
    link_flags_t             tail_fl;
    logic [FW-1:0]           frame_sel;
    logic                    do_evict;
    cell_cmd_t               cmd;

    // Configuration writes; all four codes are defined
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_shift_reg <= PAGE_SHIFT_RST;
            vpages_cfg_reg <= VPAGES_RST;
            frames_cfg_reg <= FRAMES_RST;
            policy_reg     <= POLICY_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PAGE_SHIFT: page_shift_reg <= cfg_wdata[PAGE_SHIFT_W-1:0];
                REG_VPAGES:     vpages_cfg_reg <= cfg_wdata[VPAGES_CFG_W-1:0];
                REG_FRAMES:     frames_cfg_reg <= cfg_wdata[FRAMES_CFG_W-1:0];
                REG_POLICY:     policy_reg     <= cfg_wdata[0];
            endcase
        end
    end

    // Saturate the configuration into legal ranges
    always_comb begin
        logic [31:0] vp_sat;
        logic [31:0] fr_sat;
        if (32'(page_shift_reg) > 32'(MAX_PAGE_SHIFT)) begin
            shift_eff = SHW'(MAX_PAGE_SHIFT);
        end else begin
            shift_eff = SHW'(page_shift_reg);
        end
        vp_sat = 32'(vpages_cfg_reg);
        if (vp_sat == 32'd0) begin
            vp_sat = 32'd1;
        end else if (vp_sat > 32'(VIRT_PAGES)) begin
            vp_sat = 32'(VIRT_PAGES);
        end
        fr_sat = 32'(frames_cfg_reg);
        if (fr_sat == 32'd0) begin
            fr_sat = 32'd1;
        end else if (fr_sat > 32'(PHYS_FRAMES)) begin
            fr_sat = 32'(PHYS_FRAMES);
        end
        if (fr_sat > vp_sat) begin
            fr_sat = vp_sat;
        end
        vpages_eff  = VPW'(vp_sat);
        nframes_eff = NFW'(fr_sat);
    end

    // Range check, page number and offset
    assign limit_cmp = CMPW'(vpages_eff) << shift_eff;
    assign addr_oor  = CMPW'(addr_reg) >= limit_cmp;
    assign page_cur  = PW'(addr_reg >> shift_eff);
    assign off_mask  = (MW'(1) << shift_eff) - MW'(1);
    assign phys_calc = (PHYS_ADDR_W'(frame_sel) << shift_eff)
                     | (addr_reg[PHYS_ADDR_W-1:0] & off_mask[PHYS_ADDR_W-1:0]);

    // Chain head: an empty record launched in the check cycle
    assign lk_fl[0]         = '{valid: launch, hit: 1'b0, free_found: 1'b0, have: 1'b0};
    assign lk_hit_frame[0]  = '0;
    assign lk_free_frame[0] = '0;
    assign lk_best_frame[0] = '0;
    assign lk_best_owner[0] = '0;
    assign lk_best_stamp[0] = '0;

    // Row of frame cells
    for (genvar g = 0; g < PHYS_FRAMES; g++) begin : g_cell
        dpt_frame_cell #(
            .VIRT_PAGES  (VIRT_PAGES),
            .PHYS_FRAMES (PHYS_FRAMES),
            .CELL_IDX    (g)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .page_i       (page_cur),
            .nframes_i    (nframes_eff),
            .policy_i     (policy_reg),
            .cmd_i        (cmd),
            .cmd_frame_i  (frame_sel),
            .cmd_page_i   (page_cur),
            .cmd_stamp_i  (tick_reg),
            .fl_i         (lk_fl[g]),
            .hit_frame_i  (lk_hit_frame[g]),
            .free_frame_i (lk_free_frame[g]),
            .best_frame_i (lk_best_frame[g]),
            .best_owner_i (lk_best_owner[g]),
            .best_stamp_i (lk_best_stamp[g]),
            .fl_o         (lk_fl[g+1]),
            .hit_frame_o  (lk_hit_frame[g+1]),
            .free_frame_o (lk_free_frame[g+1]),
            .best_frame_o (lk_best_frame[g+1]),
            .best_owner_o (lk_best_owner[g+1]),
            .best_stamp_o (lk_best_stamp[g+1])
        );
    end

    // Frame choice from the finished walk: hit, else free, else victim
    assign tail_fl = lk_fl[PHYS_FRAMES];
    always_comb begin
        frame_sel = lk_best_frame[PHYS_FRAMES];
        do_evict  = tail_fl.have;
        priority if (tail_fl.hit) begin
            frame_sel = lk_hit_frame[PHYS_FRAMES];
            do_evict  = 1'b0;
        end else if (tail_fl.free_found) begin
            frame_sel = lk_free_frame[PHYS_FRAMES];
            do_evict  = 1'b0;
        end else begin
            frame_sel = lk_best_frame[PHYS_FRAMES];
            do_evict  = tail_fl.have;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        tick_next       = tick_reg;
        oor_next        = oor_reg;
        m_valid_next    = m_valid_reg;
        m_phys_next     = m_phys_reg;
        m_oor_next      = m_oor_reg;
        m_hit_next      = m_hit_reg;
        m_ev_valid_next = m_ev_valid_reg;
        m_ev_page_next  = m_ev_page_reg;
        launch          = 1'b0;
        cmd             = '0;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    addr_next  = s_virt_addr;
                    tick_next  = tick_reg + 32'd1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                oor_next = addr_oor;
                if (addr_oor) begin
                    state_next = ST_DONE;
                end else begin
                    launch     = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (tail_fl.valid) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (oor_reg) begin
                        m_phys_next     = '0;
                        m_oor_next      = 1'b1;
                        m_hit_next      = 1'b0;
                        m_ev_valid_next = 1'b0;
                        m_ev_page_next  = '0;
                    end else begin
                        m_phys_next     = phys_calc;
                        m_oor_next      = 1'b0;
                        m_hit_next      = tail_fl.hit;
                        m_ev_valid_next = do_evict;
                        m_ev_page_next  = do_evict ?
                                          EVICT_PAGE_W'(lk_best_owner[PHYS_FRAMES]) : '0;
                        cmd.touch       = tail_fl.hit;
                        cmd.load        = !tail_fl.hit;
                    end
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        oor_reg        <= oor_next;
        m_phys_reg     <= m_phys_next;
        m_oor_reg      <= m_oor_next;
        m_hit_reg      <= m_hit_next;
        m_ev_valid_reg <= m_ev_valid_next;
        m_ev_page_reg  <= m_ev_page_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_phys_addr     = m_phys_reg;
    assign m_out_of_range  = m_oor_reg;
    assign m_was_hit       = m_hit_reg;
    assign m_evicted_valid = m_ev_valid_reg;
    assign m_evicted_page  = m_ev_page_reg;

    // Checks
    `DPT_ASSERT_IMP(a_oor_result_clear, m_valid && m_out_of_range, (m_phys_addr == '0) && !m_was_hit && !m_evicted_valid && (m_evicted_page == '0), "out-of-range result carries translation data")
    `DPT_ASSERT_IMP(a_evict_only_on_fault, m_valid && m_evicted_valid, !m_was_hit, "eviction reported on a hit")
    `DPT_ASSERT_IMP(a_walk_ends_in_walk, tail_fl.valid, state_reg == ST_WALK, "search record left the row outside a walk")
    `DPT_ASSERT_NXT(a_accept_steps_tick, s_valid && s_ready, (state_reg == ST_CHECK) && (tick_reg == $past(tick_reg) + 32'd1), "input transfer did not start a check with one tick")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Demand paging translator testbench
// Sends virtual addresses over the s_ channel and checks each translation on
// the m_ channel against an in-bench page table model with FIFO and LRU
// replacement. Directed cases cover the address extremes, out-of-range
// addresses, both victim policies, saturated sizes and a shrunken frame
// count. These are followed by random traffic over many register settings,
// with random stalls on both sides.
// ----------------------------------------------------------------------------

module testbench;
    import dpt_pkg::*;

    localparam int NUM_PAGES     = VIRT_PAGES_DEF;
    localparam int NUM_FRAMES    = PHYS_FRAMES_DEF;
    localparam int SHIFT_MAX     = MAX_PAGE_SHIFT_DEF;
    localparam int ADDR_MAX      = (1 << ADDR_W) - 1;
    localparam int SETTLE_CYCLES = PHYS_FRAMES_DEF + 8;
    localparam int IDLE_PCT      = 36;

    // One translation as seen on the result channel
    typedef struct packed {
        logic [PHYS_ADDR_W-1:0]  phys;
        logic                    oor;
        logic                    hit;
        logic                    evicted;
        logic [EVICT_PAGE_W-1:0] evicted_page;
    } xlat_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [ADDR_W-1:0]       s_virt_addr = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [PHYS_ADDR_W-1:0]  m_phys_addr;
    logic                    m_out_of_range;
    logic                    m_was_hit;
    logic                    m_evicted_valid;
    logic [EVICT_PAGE_W-1:0] m_evicted_page;

    // Shadow registers
    logic [PAGE_SHIFT_W-1:0] cfg_shift  = PAGE_SHIFT_RST;
    logic [VPAGES_CFG_W-1:0] cfg_vpages = VPAGES_RST;
    logic [FRAMES_CFG_W-1:0] cfg_frames = FRAMES_RST;
    logic                    cfg_lru    = POLICY_RST;

    // Page table and frame model
    bit                    pt_valid  [NUM_PAGES];
    bit [3:0]              pt_frame  [NUM_PAGES];
    bit [STAMP_W-1:0]      pt_loaded [NUM_PAGES];
    bit [STAMP_W-1:0]      pt_used   [NUM_PAGES];
    bit [EVICT_PAGE_W-1:0] frm_owner [NUM_FRAMES];
    bit                    frm_busy  [NUM_FRAMES];
    bit [STAMP_W-1:0]      ticks = '0;

    xlat_t pending_xlat[$];
    int    mismatch_count = 0;
    bit    steady_flow = 1'b0;

    demand_paging_translator_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_virt_addr     (s_virt_addr),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_phys_addr     (m_phys_addr),
        .m_out_of_range  (m_out_of_range),
        .m_was_hit       (m_was_hit),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page)
    );

    always #5 aclk = ~aclk;

    // Result side backpressure
    always @(negedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Effective sizes after saturation
    function automatic int eff_shift();
        return (cfg_shift > SHIFT_MAX) ? SHIFT_MAX : int'(cfg_shift);
    endfunction

    function automatic int eff_vpages();
        if (cfg_vpages == 0) return 1;
        return (cfg_vpages > NUM_PAGES) ? NUM_PAGES : int'(cfg_vpages);
    endfunction

    function automatic int eff_frames();
        int n;
        n = (cfg_frames == 0) ? 1 : int'(cfg_frames);
        if (n > NUM_FRAMES) n = NUM_FRAMES;
        if (n > eff_vpages()) n = eff_vpages();
        return n;
    endfunction

    // Translate one address and update the page table
    function automatic xlat_t predict_translation(input logic [ADDR_W-1:0] va);
        xlat_t            r;
        int               sh, nf, page, frame, best_f, f, owner;
        longint           lim, offset;
        bit               found, have;
        bit [STAMP_W-1:0] best, s;
        r = '0;
        sh = eff_shift();
        nf = eff_frames();
        ticks = ticks + 1;
        lim = longint'(eff_vpages()) << sh;
        if (longint'(va) >= lim) begin
            r.oor = 1'b1;
            return r;
        end
        page = int'(va >> sh);
        offset = longint'(va) & ((longint'(1) << sh) - 1);
        if (pt_valid[page]) begin
            r.hit = 1'b1;
            pt_used[page] = ticks;
            frame = pt_frame[page];
        end else begin
            found = 1'b0;
            frame = 0;
            // lowest free frame first
            for (f = 0; f < nf; f++) begin
                if (!found && !frm_busy[f]) begin
                    frame = f;
                    found = 1'b1;
                end
            end
            if (!found) begin
                // oldest stamp wins, lowest frame on a tie
                have = 1'b0;
                best = '0;
                best_f = 0;
                for (f = 0; f < nf; f++) begin
                    if (frm_busy[f] && pt_valid[frm_owner[f]]) begin
                        s = cfg_lru ? pt_used[frm_owner[f]] : pt_loaded[frm_owner[f]];
                        if (!have || s < best) begin
                            have = 1'b1;
                            best = s;
                            best_f = f;
                        end
                    end
                end
                frame = have ? best_f : 0;
                if (frm_busy[frame]) begin
                    owner = frm_owner[frame];
                    r.evicted = 1'b1;
                    r.evicted_page = owner;
                    pt_valid[owner] = 1'b0;
                    pt_frame[owner] = '0;
                end
                frm_busy[frame] = 1'b0;
                frm_owner[frame] = '0;
            end
            pt_valid[page] = 1'b1;
            pt_frame[page] = frame;
            pt_loaded[page] = ticks;
            pt_used[page] = ticks;
            frm_owner[frame] = page;
            frm_busy[frame] = 1'b1;
        end
        r.phys = PHYS_ADDR_W'((longint'(frame) << sh) + offset);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Result checker
    always @(posedge aclk) begin : check_results
        xlat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_xlat.size() == 0) begin
                report_mismatch("unexpected transfer", m_phys_addr, 0);
            end else begin
                want = pending_xlat.pop_front();
                if (m_phys_addr !== want.phys)
                    report_mismatch("phys_addr", m_phys_addr, want.phys);
                if (m_out_of_range !== want.oor)
                    report_mismatch("out_of_range", m_out_of_range, want.oor);
                if (m_was_hit !== want.hit)
                    report_mismatch("was_hit", m_was_hit, want.hit);
                if (m_evicted_valid !== want.evicted)
                    report_mismatch("evicted_valid", m_evicted_valid, want.evicted);
                if (m_evicted_page !== want.evicted_page)
                    report_mismatch("evicted_page", m_evicted_page, want.evicted_page);
            end
        end
    end

    // Send one address; entered and left just after a falling edge.
    // Valid stays high on return so back-to-back transfers need no toggle.
    task automatic send_addr(input int va);
        int gap;
        gap = 0;
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_virt_addr <= ADDR_W'(va);
        do @(posedge aclk); while (!s_ready);
        pending_xlat.push_back(predict_translation(ADDR_W'(va)));
        @(negedge aclk);
    endtask

    // Hold off the sender until every result is back and the block is idle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_xlat.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        case (idx)
            REG_PAGE_SHIFT: cfg_shift = PAGE_SHIFT_W'(val);
            REG_VPAGES:     cfg_vpages = VPAGES_CFG_W'(val);
            REG_FRAMES:     cfg_frames = FRAMES_CFG_W'(val);
            REG_POLICY:     cfg_lru = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_config(input int sh, input int vp, input int fr, input int pol);
        drain_results();
        write_reg(REG_PAGE_SHIFT, sh);
        write_reg(REG_VPAGES, vp);
        write_reg(REG_FRAMES, fr);
        write_reg(REG_POLICY, pol);
    endtask

    // Lowest and highest addresses under reset settings, fault then hit
    task automatic test_extremes();
        send_addr(0);
        send_addr(ADDR_MAX);
        send_addr(ADDR_MAX);
        send_addr(0);
    endtask

    // One-page and one-byte virtual spaces; oversized shift saturates
    task automatic test_out_of_range();
        apply_config(0, 1, 1, 0);
        send_addr(0);
        send_addr(1);
        send_addr(ADDR_MAX);
        apply_config(15, 0, 0, 1);
        send_addr(4095);
        send_addr(4096);
    endtask

    // Two frames, 16-byte pages; victim is the oldest load
    task automatic test_fifo_replacement();
        apply_config(4, 8, 2, 0);
        send_addr(2 * 16 + 15);
        send_addr(3 * 16);
        send_addr(2 * 16 + 7);
        send_addr(4 * 16 + 1);
        send_addr(3 * 16 + 15);
    endtask

    // Same shape, victim is the least recently used page
    task automatic test_lru_replacement();
        apply_config(4, 8, 2, 1);
        send_addr(5 * 16);
        send_addr(3 * 16 + 3);
        send_addr(6 * 16 + 15);
        send_addr(3 * 16 + 9);
        send_addr(7 * 16 + 2);
    endtask

    // Oversized counts saturate; pages in frames past a shrunken count still hit
    task automatic test_saturated_sizes();
        apply_config(12, 127, 31, 0);
        send_addr(ADDR_MAX);
        send_addr(40 * 4096 + 123);
        apply_config(12, 64, 2, 1);
        send_addr(40 * 4096 + 4095);
        send_addr(50 * 4096);
    endtask

    // Random traffic over a sweep of register settings
    task automatic test_random_traffic();
        int presets[8][4] = '{
            '{12, 64, 16, 0}, '{0, 1, 1, 1}, '{15, 127, 31, 0}, '{0, 0, 0, 1},
            '{4, 64, 4, 1}, '{6, 20, 31, 0}, '{12, 2, 1, 1}, '{2, 64, 16, 1}
        };
        int ph, i, sh, vp, fr, pol, ws, base, page, va;
        for (ph = 0; ph < 20; ph++) begin
            if (ph < 8) begin
                sh = presets[ph][0];
                vp = presets[ph][1];
                fr = presets[ph][2];
                pol = presets[ph][3];
            end else begin
                sh = $urandom_range(0, 15);
                vp = $urandom_range(0, 127);
                fr = $urandom_range(0, 31);
                pol = $urandom_range(0, 1);
            end
            apply_config(sh, vp, fr, pol);
            steady_flow = (ph == 0);
            // working set a little larger than the frame count forces evictions
            ws = eff_frames() + $urandom_range(1, 3);
            if (ws > eff_vpages()) ws = eff_vpages();
            base = $urandom_range(0, eff_vpages() - 1);
            for (i = 0; i < 50; i++) begin
                if (ph == 3 && i == 25) drain_results();
                if ($urandom_range(0, 99) < 80) begin
                    page = (base + $urandom_range(0, ws - 1)) % eff_vpages();
                    va = (page << eff_shift()) | $urandom_range(0, (1 << eff_shift()) - 1);
                end else begin
                    va = $urandom_range(0, ADDR_MAX);
                end
                send_addr(va);
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_extremes();
        test_out_of_range();
        test_fifo_replacement();
        test_lru_replacement();
        test_saturated_sizes();
        test_random_traffic();
        drain_results();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== demand_paging_translator_top.f =====
+incdir+hdl
hdl/dpt_pkg.sv
hdl/dpt_frame_cell.sv
hdl/demand_paging_translator_top.sv
test/testbench.sv
